@@ hw/rtl/ttv_pkg.sv @@
// Package for the triangle tangent pipeline: widths, item structs and the
// structs that pass between the pipeline sections. No dependencies.
package ttv_pkg;

    localparam int CoordW    = 32;
    localparam int DeltaW    = 33;
    localparam int ProdW     = 66;
    localparam int CompW     = 67;
    localparam int BitLenW   = 7;
    localparam int MagW      = 32;
    localparam int SumW      = 64;
    localparam int RootW     = 32;
    localparam int RemW      = 34;
    localparam int QuotW     = 31;
    localparam int FracBits  = 30;
    localparam int DivRemW   = 63;
    localparam int FrontDepth = 4;
    localparam int NormDepth  = 4;

    typedef struct packed {
        logic signed [CoordW-1:0] pos_a_x;
        logic signed [CoordW-1:0] pos_a_y;
        logic signed [CoordW-1:0] pos_a_z;
        logic signed [CoordW-1:0] pos_b_x;
        logic signed [CoordW-1:0] pos_b_y;
        logic signed [CoordW-1:0] pos_b_z;
        logic signed [CoordW-1:0] pos_c_x;
        logic signed [CoordW-1:0] pos_c_y;
        logic signed [CoordW-1:0] pos_c_z;
        logic [2*CoordW-1:0]      uv_a;
        logic [2*CoordW-1:0]      uv_b;
        logic [2*CoordW-1:0]      uv_c;
    } t_in_item;

    typedef struct packed {
        logic signed [CoordW-1:0] tangent_x;
        logic signed [CoordW-1:0] tangent_y;
        logic signed [CoordW-1:0] tangent_z;
        logic                     degenerate;
    } t_out_item;

    // component magnitudes after sign fold
    typedef struct packed {
        logic [2:0][CompW-1:0] mag;
        logic [2:0]            neg;
        logic                  degen;
    } t_mag_item;

    // scaled components and their sum of squares
    typedef struct packed {
        logic [2:0][MagW-1:0] m;
        logic [2:0]           neg;
        logic                 degen;
        logic [SumW-1:0]      sum;
    } t_norm_item;

    // scaled components and vector length
    typedef struct packed {
        logic [2:0][MagW-1:0] m;
        logic [2:0]           neg;
        logic                 degen;
        logic [RootW-1:0]     len;
    } t_len_item;

endpackage

@@ hw/rtl/triangle_tangent_vector.sv @@
// Per-triangle unit tangent from vertex positions and texture coordinates.
// Pipeline from input accept to result valid: 4 front, 4 normalize, 32 root,
// 31 divide and 1 output register stages; the root and divider give one bit per stage.
// Throughput: one item per cycle; a stalled output holds the whole pipeline.
// Reset: synchronous active low; clears all stage valid bits.
// Uses ttv_pkg, ttv_front, ttv_norm, ttv_sqrt and ttv_div.
module triangle_tangent_vector (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  ttv_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output ttv_pkg::t_out_item o_item
);
    import ttv_pkg::*;

    logic       en;
    logic       front_v, norm_v, sqrt_v;
    t_mag_item  front_d;
    t_norm_item norm_d;
    t_len_item  sqrt_d;

    // advance everything unless the output item is waiting
    assign en      = i_ready || !o_valid;
    assign o_ready = en;

    ttv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_valid (front_v),
        .o_item  (front_d)
    );

    ttv_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_v),
        .i_item  (front_d),
        .o_valid (norm_v),
        .o_item  (norm_d)
    );

    ttv_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (norm_v),
        .i_item  (norm_d),
        .o_valid (sqrt_v),
        .o_item  (sqrt_d)
    );

    ttv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sqrt_v),
        .i_item  (sqrt_d),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

`ifndef SYNTH
    a_degen_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.degenerate |->
            o_item.tangent_x == '0 && o_item.tangent_y == '0 && o_item.tangent_z == '0)
        else $error("degenerate item with nonzero tangent");

    a_unit_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_item.degenerate |->
            o_item.tangent_x <= 32'sd1073741824 && o_item.tangent_x >= -32'sd1073741824 &&
            o_item.tangent_y <= 32'sd1073741824 && o_item.tangent_y >= -32'sd1073741824 &&
            o_item.tangent_z <= 32'sd1073741824 && o_item.tangent_z >= -32'sd1073741824)
        else $error("tangent component exceeds unit range");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");
`endif

endmodule

@@ hw/rtl/ttv_front.sv @@
// Front section: edges, texture deltas, products, components and determinant,
// then sign fold to magnitudes. Four register stages. Uses ttv_pkg.
module ttv_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  ttv_pkg::t_in_item   i_item,
    output logic                o_valid,
    output ttv_pkg::t_mag_item  o_item
);
    import ttv_pkg::*;

    function automatic logic signed [DeltaW-1:0] f_dif(input logic [CoordW-1:0] a,
                                                       input logic [CoordW-1:0] b);
        logic signed [DeltaW-1:0] sa, sb;
        sa = $signed({a[CoordW-1], a});
        sb = $signed({b[CoordW-1], b});
        return sa - sb;
    endfunction

    logic [FrontDepth-1:0] r_v;

    logic signed [DeltaW-1:0] r_e0 [3];
    logic signed [DeltaW-1:0] r_e1 [3];
    logic signed [DeltaW-1:0] r_du0, r_du1, r_dv0, r_dv1;

    logic signed [ProdW-1:0] r_p1 [3];
    logic signed [ProdW-1:0] r_p2 [3];
    logic signed [ProdW-1:0] r_pd1, r_pd2;

    logic signed [CompW-1:0] r_c [3];
    logic signed [CompW-1:0] r_det;

    t_mag_item r_out;
    t_mag_item n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[FrontDepth-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e0[0] <= f_dif(i_item.pos_a_x, i_item.pos_b_x);
            r_e0[1] <= f_dif(i_item.pos_a_y, i_item.pos_b_y);
            r_e0[2] <= f_dif(i_item.pos_a_z, i_item.pos_b_z);
            r_e1[0] <= f_dif(i_item.pos_c_x, i_item.pos_b_x);
            r_e1[1] <= f_dif(i_item.pos_c_y, i_item.pos_b_y);
            r_e1[2] <= f_dif(i_item.pos_c_z, i_item.pos_b_z);
            r_du0   <= f_dif(i_item.uv_a[CoordW-1:0], i_item.uv_b[CoordW-1:0]);
            r_du1   <= f_dif(i_item.uv_c[CoordW-1:0], i_item.uv_b[CoordW-1:0]);
            r_dv0   <= f_dif(i_item.uv_a[2*CoordW-1:CoordW], i_item.uv_b[2*CoordW-1:CoordW]);
            r_dv1   <= f_dif(i_item.uv_c[2*CoordW-1:CoordW], i_item.uv_b[2*CoordW-1:CoordW]);

            for (int i = 0; i < 3; i++) begin
                r_p1[i] <= r_dv1 * r_e0[i];
                r_p2[i] <= r_dv0 * r_e1[i];
                r_c[i]  <= $signed({r_p1[i][ProdW-1], r_p1[i]})
                         - $signed({r_p2[i][ProdW-1], r_p2[i]});
            end
            r_pd1 <= r_du0 * r_dv1;
            r_pd2 <= r_du1 * r_dv0;
            r_det <= $signed({r_pd1[ProdW-1], r_pd1}) - $signed({r_pd2[ProdW-1], r_pd2});

            r_out <= n_out;
        end
    end

    // fold the determinant sign in, then split sign and magnitude
    always_comb begin
        logic signed [CompW-1:0] cn;
        logic                    all_zero;
        n_out    = '0;
        all_zero = 1'b1;
        for (int i = 0; i < 3; i++) begin
            cn = r_det[CompW-1] ? -r_c[i] : r_c[i];
            n_out.neg[i] = cn[CompW-1];
            n_out.mag[i] = cn[CompW-1] ? CompW'(-cn) : CompW'(cn);
            if (cn != '0) begin
                all_zero = 1'b0;
            end
        end
        n_out.degen = (r_det == '0) || all_zero;
    end

    assign o_valid = r_v[FrontDepth-1];
    assign o_item  = r_out;

endmodule

@@ hw/rtl/ttv_norm.sv @@
// Normalize section: bit length, scale to 31 bits, squares and their sum.
// Four register stages. Uses ttv_pkg.
module ttv_norm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  ttv_pkg::t_mag_item  i_item,
    output logic                o_valid,
    output ttv_pkg::t_norm_item o_item
);
    import ttv_pkg::*;

    logic [NormDepth-1:0] r_v;

    t_mag_item            r_mag;
    logic [BitLenW-1:0]   r_len;
    logic [BitLenW-1:0]   n_len;

    logic [2:0][MagW-1:0] r_m1, r_m2;
    logic [2:0][MagW-1:0] n_m;
    logic [2:0]           r_neg1, r_neg2;
    logic                 r_dg1, r_dg2;
    logic [2*MagW-1:0]    r_sq [3];
    t_norm_item           r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NormDepth-2:0], i_valid};
        end
    end

    // bit length (top set bit position plus one) over all three magnitudes
    always_comb begin
        logic [CompW-1:0] all;
        all   = i_item.mag[0] | i_item.mag[1] | i_item.mag[2];
        n_len = '0;
        for (int b = 0; b < CompW; b++) begin
            if (all[b]) begin
                n_len = BitLenW'(b + 1);
            end
        end
    end

    // scale so the largest magnitude lands in [2^30, 2^31)
    always_comb begin
        logic [CompW-1:0] sh;
        for (int i = 0; i < 3; i++) begin
            if (r_len > BitLenW'(MagW - 1)) begin
                sh = r_mag.mag[i] >> (r_len - BitLenW'(MagW - 1));
            end else begin
                sh = r_mag.mag[i] << (BitLenW'(MagW - 1) - r_len);
            end
            n_m[i] = sh[MagW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag  <= i_item;
            r_len  <= n_len;

            r_m1   <= n_m;
            r_neg1 <= r_mag.neg;
            r_dg1  <= r_mag.degen;

            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= r_m1[i] * r_m1[i];
            end
            r_m2   <= r_m1;
            r_neg2 <= r_neg1;
            r_dg2  <= r_dg1;

            r_out.sum   <= r_sq[0] + r_sq[1] + r_sq[2];
            r_out.m     <= r_m2;
            r_out.neg   <= r_neg2;
            r_out.degen <= r_dg2;
        end
    end

    assign o_valid = r_v[NormDepth-1];
    assign o_item  = r_out;

endmodule

@@ hw/rtl/ttv_sqrt.sv @@
// Square root section: digit-by-digit integer root, one result bit per
// register stage, 32 stages. Uses ttv_pkg.
module ttv_sqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  ttv_pkg::t_norm_item i_item,
    output logic                o_valid,
    output ttv_pkg::t_len_item  o_item
);
    import ttv_pkg::*;

    logic [RootW-1:0] r_v;
    logic [RemW-1:0]  r_rem  [RootW];
    logic [RootW-1:0] r_root [RootW];
    t_norm_item       r_d    [RootW];

    for (genvar j = 0; j < RootW; j++) begin : g_step
        logic [RemW-1:0]   rem_in;
        logic [RootW-1:0]  root_in;
        t_norm_item        d_in;
        logic              v_in;
        logic [RemW+1:0]   acc;
        logic [RemW+1:0]   trial;

        if (j == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign d_in    = i_item;
            assign v_in    = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
            assign d_in    = r_d[j-1];
            assign v_in    = r_v[j-1];
        end

        assign acc   = {rem_in, d_in.sum[2*(RootW-1-j)+1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (acc >= trial) begin
                    r_rem[j]  <= RemW'(acc - trial);
                    r_root[j] <= {root_in[RootW-2:0], 1'b1};
                end else begin
                    r_rem[j]  <= acc[RemW-1:0];
                    r_root[j] <= {root_in[RootW-2:0], 1'b0};
                end
                r_d[j] <= d_in;
            end
        end
    end

    always_comb begin
        o_item.m     = r_d[RootW-1].m;
        o_item.neg   = r_d[RootW-1].neg;
        o_item.degen = r_d[RootW-1].degen;
        o_item.len   = (r_root[RootW-1] == '0) ? RootW'(1) : r_root[RootW-1];
    end

    assign o_valid = r_v[RootW-1];

endmodule

@@ hw/rtl/ttv_div.sv @@
// Divide section: rounded quotient m * 2^30 / len for three lanes, one
// quotient bit per stage, then the signed output register. Uses ttv_pkg.
module ttv_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  ttv_pkg::t_len_item  i_item,
    output logic                o_valid,
    output ttv_pkg::t_out_item  o_item
);
    import ttv_pkg::*;

    logic [QuotW-1:0]             r_v;
    logic [2:0][DivRemW-1:0]      r_rem [QuotW];
    logic [2:0][QuotW-1:0]        r_q   [QuotW];
    t_len_item                    r_d   [QuotW];
    logic                         r_out_v;
    t_out_item                    r_out;
    t_out_item                    n_out;

    for (genvar j = 0; j < QuotW; j++) begin : g_step
        localparam int K = QuotW - 1 - j;
        logic [2:0][DivRemW-1:0] rem_in;
        logic [2:0][QuotW-1:0]   q_in;
        t_len_item               d_in;
        logic                    v_in;
        logic [DivRemW:0]        dv;

        if (j == 0) begin : g_first
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign rem_in[i] = DivRemW'({i_item.m[i], {FracBits{1'b0}}})
                                 + DivRemW'(i_item.len >> 1);
            end
            assign q_in = '0;
            assign d_in = i_item;
            assign v_in = i_valid;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign q_in   = r_q[j-1];
            assign d_in   = r_d[j-1];
            assign v_in   = r_v[j-1];
        end

        assign dv = (DivRemW + 1)'(d_in.len) << K;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    if ({1'b0, rem_in[i]} >= dv) begin
                        r_rem[j][i] <= DivRemW'({1'b0, rem_in[i]} - dv);
                        r_q[j][i]   <= q_in[i] | (QuotW'(1) << K);
                    end else begin
                        r_rem[j][i] <= rem_in[i];
                        r_q[j][i]   <= q_in[i];
                    end
                end
                r_d[j] <= d_in;
            end
        end
    end

    // apply signs, zero the tangent for a degenerate triangle
    always_comb begin
        logic [2:0][CoordW-1:0] t;
        for (int i = 0; i < 3; i++) begin
            if (r_d[QuotW-1].degen) begin
                t[i] = '0;
            end else if (r_d[QuotW-1].neg[i]) begin
                t[i] = CoordW'(-{1'b0, r_q[QuotW-1][i]});
            end else begin
                t[i] = {1'b0, r_q[QuotW-1][i]};
            end
        end
        n_out.tangent_x  = $signed(t[0]);
        n_out.tangent_y  = $signed(t[1]);
        n_out.tangent_z  = $signed(t[2]);
        n_out.degenerate = r_d[QuotW-1].degen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= r_v[QuotW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_v;
    assign o_item  = r_out;

endmodule
